[hdl/josephus_survivor_defines.svh]
// assertion macros for the josephus survivor block
// expects aclk and aresetn in the scope of each use
`ifndef JOSEPHUS_SURVIVOR_DEFINES_SVH
`define JOSEPHUS_SURVIVOR_DEFINES_SVH

// same-cycle implication, off during reset
`define JOS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define JOS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/jos_pkg.sv]
// shared constants, types and the control store for the josephus survivor block
// no dependencies
package jos_pkg;

    localparam int MAX_MEMBERS = 512;
    localparam int MEMBER_W    = $clog2(MAX_MEMBERS);
    localparam int SIZE_W      = 10;
    localparam int STEP_W      = 16;
    localparam int DIV_STEPS   = STEP_W;
    localparam int CNT_W       = $clog2(DIV_STEPS + 1);
    localparam int PC_W        = 4;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_BUILD,
        ACT_MOD_START,
        ACT_LOAD_WALK,
        ACT_READ,
        ACT_ADVANCE,
        ACT_UNLINK,
        ACT_PUBLISH,
        ACT_PUBLISH_ERR
    } act_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_SIZE_ZERO,
        C_BUILD_MORE,
        C_MOD_BUSY,
        C_WALK_ZERO,
        C_RING_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    // program addresses
    localparam pc_t P_IDLE     = pc_t'(0);
    localparam pc_t P_ZCHK     = pc_t'(1);
    localparam pc_t P_BUILD    = pc_t'(2);
    localparam pc_t P_MSTART   = pc_t'(3);
    localparam pc_t P_MWAIT    = pc_t'(4);
    localparam pc_t P_WALK     = pc_t'(5);
    localparam pc_t P_ADV      = pc_t'(6);
    localparam pc_t P_UNLINK   = pc_t'(7);
    localparam pc_t P_PUB      = pc_t'(8);
    localparam pc_t P_PUB_DONE = pc_t'(9);
    localparam pc_t P_ERR      = pc_t'(10);
    localparam pc_t P_ERR_DONE = pc_t'(11);

    // control store: taken condition jumps to target, otherwise fall through
    function automatic ctrl_word_t ucode_rom(input pc_t pc);
        ctrl_word_t cw;
        unique case (pc)
            P_IDLE:     cw = '{ACT_ACCEPT,      C_NO_INPUT,   P_IDLE};
            P_ZCHK:     cw = '{ACT_NONE,        C_SIZE_ZERO,  P_ERR};
            P_BUILD:    cw = '{ACT_BUILD,       C_BUILD_MORE, P_BUILD};
            P_MSTART:   cw = '{ACT_MOD_START,   C_NEVER,      P_IDLE};
            P_MWAIT:    cw = '{ACT_LOAD_WALK,   C_MOD_BUSY,   P_MWAIT};
            P_WALK:     cw = '{ACT_READ,        C_WALK_ZERO,  P_UNLINK};
            P_ADV:      cw = '{ACT_ADVANCE,     C_ALWAYS,     P_WALK};
            P_UNLINK:   cw = '{ACT_UNLINK,      C_RING_MORE,  P_MSTART};
            P_PUB:      cw = '{ACT_PUBLISH,     C_OUT_BUSY,   P_PUB};
            P_PUB_DONE: cw = '{ACT_NONE,        C_ALWAYS,     P_IDLE};
            P_ERR:      cw = '{ACT_PUBLISH_ERR, C_OUT_BUSY,   P_ERR};
            P_ERR_DONE: cw = '{ACT_NONE,        C_ALWAYS,     P_IDLE};
            default:    cw = '{ACT_NONE,        C_ALWAYS,     P_IDLE};
        endcase
        return cw;
    endfunction

endpackage

[hdl/jos_divmod.sv]
// restoring remainder unit, one quotient bit per cycle
// depends on jos_pkg
module jos_divmod import jos_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [STEP_W-1:0]   dividend,
    input  logic [SIZE_W-1:0]   divisor,
    output logic                busy,
    output logic [MEMBER_W-1:0] remainder
);

    logic [STEP_W-1:0] dvd_reg, dvd_next;
    logic [SIZE_W-1:0] div_reg, div_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W:0]   trial;
    logic              fits;

    assign busy      = (cnt_reg != '0);
    assign trial     = {rem_reg, dvd_reg[STEP_W-1]};
    assign fits      = (trial >= {1'b0, div_reg});
    // remainder stays below the divisor, which is at most the member count
    assign remainder = rem_reg[MEMBER_W-1:0];

    always_comb begin
        dvd_next = dvd_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start) begin
            dvd_next = dividend;
            div_next = divisor;
            rem_next = '0;
            cnt_next = CNT_W'(DIV_STEPS);
        end else if (busy) begin
            dvd_next = {dvd_reg[STEP_W-2:0], 1'b0};
            rem_next = fits ? SIZE_W'(trial - {1'b0, div_reg}) : trial[SIZE_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

endmodule

[hdl/josephus_survivor.sv]
// per item: accept the input beat, build a ring of n members, then one round per ring size r
// from n down to 2 (one round for n = 1), each walking (m-1) mod r links, m = 0 as 1, as given
// by the remainder unit, then unlinking one member; a zero size goes straight to the error answer
// throughput: one item at a time; s_ready returns once the result is loaded and P_PUB_DONE
// has gone back to P_IDLE, and loading waits only while an earlier result is still unaccepted
// reset (sync, active low) idles the sequencer and drops m_valid; link tables are not cleared
`include "josephus_survivor_defines.svh"

module josephus_survivor import jos_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [SIZE_W-1:0] s_circle_size,
    input  logic [STEP_W-1:0] s_step_count,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SIZE_W-1:0] m_survivor,
    output logic              m_size_error
);

    // sequencer
    pc_t        pc_reg, pc_next;
    ctrl_word_t cw;
    logic       taken;

    // datapath
    logic [MEMBER_W-1:0] next_link_mem [MAX_MEMBERS];
    logic [MEMBER_W-1:0] prev_link_mem [MAX_MEMBERS];
    logic [MEMBER_W-1:0] next_rd_reg, prev_rd_reg;
    logic [MEMBER_W-1:0] cur_reg, cur_next;
    logic [MEMBER_W-1:0] idx_reg, idx_next;
    logic [MEMBER_W-1:0] nm1_reg, nm1_next;
    logic [MEMBER_W-1:0] walk_reg, walk_next;
    logic [MEMBER_W-1:0] before_reg, before_next;
    logic [SIZE_W-1:0]   remaining_reg, remaining_next;
    logic [STEP_W-1:0]   skip_reg, skip_next;
    logic                zero_reg, zero_next;
    logic                m_valid_reg, m_valid_next;
    logic [SIZE_W-1:0]   m_survivor_reg, m_survivor_next;
    logic                m_size_error_reg, m_size_error_next;
    logic [SIZE_W-1:0]   size_clamp;
    logic                accept;
    logic                out_free;
    logic                ring_more;
    logic                mod_busy;
    logic [MEMBER_W-1:0] mod_rem;
    logic                wr_en;
    logic [MEMBER_W-1:0] nl_wr_addr, nl_wr_data, pl_wr_addr, pl_wr_data;

    assign cw        = ucode_rom(pc_reg);
    assign s_ready   = (cw.act == ACT_ACCEPT);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign ring_more = (prev_rd_reg != next_rd_reg);
    assign size_clamp = (s_circle_size > SIZE_W'(MAX_MEMBERS)) ? SIZE_W'(MAX_MEMBERS)
                                                               : s_circle_size;

    assign m_valid      = m_valid_reg;
    assign m_survivor   = m_survivor_reg;
    assign m_size_error = m_size_error_reg;

    jos_divmod u_divmod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cw.act == ACT_MOD_START),
        .dividend  (skip_reg),
        .divisor   (remaining_reg),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    // branch condition and step counter
    always_comb begin
        unique case (cw.cond)
            C_NEVER:      taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_NO_INPUT:   taken = !s_valid;
            C_SIZE_ZERO:  taken = zero_reg;
            C_BUILD_MORE: taken = (idx_reg != nm1_reg);
            C_MOD_BUSY:   taken = mod_busy;
            C_WALK_ZERO:  taken = (walk_reg == '0);
            C_RING_MORE:  taken = ring_more;
            C_OUT_BUSY:   taken = !out_free;
            default:      taken = 1'b1;
        endcase
        pc_next = taken ? cw.target : pc_t'(pc_reg + 1'b1);
    end

    // datapath actions
    always_comb begin
        cur_next          = cur_reg;
        idx_next          = idx_reg;
        nm1_next          = nm1_reg;
        walk_next         = walk_reg;
        before_next       = before_reg;
        remaining_next    = remaining_reg;
        skip_next         = skip_reg;
        zero_next         = zero_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_survivor_next   = m_survivor_reg;
        m_size_error_next = m_size_error_reg;
        unique case (cw.act)
            ACT_ACCEPT: begin
                if (accept) begin
                    zero_next      = (s_circle_size == '0);
                    nm1_next       = MEMBER_W'(size_clamp - 1'b1);
                    remaining_next = size_clamp;
                    skip_next      = (s_step_count == '0) ? '0 : s_step_count - 1'b1;
                    idx_next       = '0;
                end
            end
            ACT_BUILD: begin
                idx_next = idx_reg + 1'b1;
                cur_next = '0;
            end
            ACT_LOAD_WALK: walk_next = mod_rem;
            ACT_ADVANCE: begin
                cur_next  = next_rd_reg;
                walk_next = walk_reg - 1'b1;
            end
            ACT_UNLINK: begin
                cur_next       = next_rd_reg;
                before_next    = prev_rd_reg;
                remaining_next = remaining_reg - 1'b1;
            end
            ACT_PUBLISH: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_survivor_next   = SIZE_W'(before_reg) + 1'b1;
                    m_size_error_next = 1'b0;
                end
            end
            ACT_PUBLISH_ERR: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_survivor_next   = '0;
                    m_size_error_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // link table write port: ring build or unlink of the current member
    always_comb begin
        wr_en = (cw.act == ACT_BUILD) || (cw.act == ACT_UNLINK);
        if (cw.act == ACT_BUILD) begin
            nl_wr_addr = idx_reg;
            nl_wr_data = (idx_reg == nm1_reg) ? '0 : idx_reg + 1'b1;
            pl_wr_addr = idx_reg;
            pl_wr_data = (idx_reg == '0) ? nm1_reg : idx_reg - 1'b1;
        end else begin
            nl_wr_addr = prev_rd_reg;
            nl_wr_data = next_rd_reg;
            pl_wr_addr = next_rd_reg;
            pl_wr_data = prev_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            next_link_mem[nl_wr_addr] <= nl_wr_data;
            prev_link_mem[pl_wr_addr] <= pl_wr_data;
        end
        if (cw.act == ACT_READ) begin
            next_rd_reg <= next_link_mem[cur_reg];
            prev_rd_reg <= prev_link_mem[cur_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= P_IDLE;
            m_valid_reg <= 1'b0;
            cur_reg     <= '0;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            cur_reg     <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg          <= idx_next;
        nm1_reg          <= nm1_next;
        walk_reg         <= walk_next;
        before_reg       <= before_next;
        remaining_reg    <= remaining_next;
        skip_reg         <= skip_next;
        zero_reg         <= zero_next;
        m_survivor_reg   <= m_survivor_next;
        m_size_error_reg <= m_size_error_next;
    end

    `JOS_ASSERT_NXT(a_walk_below_ring, (cw.act == ACT_LOAD_WALK) && !mod_busy, ({1'b0, walk_reg} < remaining_reg), "walk length not below ring size")
    `JOS_ASSERT_IMP(a_last_unlink, (cw.act == ACT_UNLINK) && !ring_more, (remaining_reg <= SIZE_W'(2)), "ring closed with more than two members")
    `JOS_ASSERT_IMP(a_result_code, $rose(m_valid_reg), (m_size_error_reg == (m_survivor_reg == '0)), "survivor and error flag disagree")

endmodule
